>>> hw/rtl/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

	localparam int BookDepth = 1024;
	localparam int AddrW = $clog2(BookDepth);
	localparam int CountW = AddrW + 1;
	localparam int PriceW = 30;
	localparam int QtyW = 30;
	localparam int TotalW = 48;
	localparam int EntryW = PriceW + QtyW;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   quantity;
		logic              is_sell;
		logic              new_batch;
	} req_t;

	typedef struct packed {
		logic [TotalW-1:0] backlog_total;
		logic [QtyW-1:0]   rested_quantity;
		logic              book_full;
	} rsp_t;

	typedef struct packed {
		logic [PriceW-1:0] price;
		logic [QtyW-1:0]   qty;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TOP_RD,
		ST_TOP_CHK,
		ST_DN_RD,
		ST_DN_CMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DONE
	} state_t;

	// controller commands to datapath
	typedef struct packed {
		logic load;       // capture request, apply clear
		logic rd_top;     // read opposite root
		logic consume;    // apply match against the top entry
		logic rd_down;    // read children of sift index
		logic step_down;  // compare children and swap if needed
		logic rest;       // write remainder at heap tail
		logic rd_up;      // read parent of sift index
		logic step_up;    // compare with parent and swap if needed
		logic done;       // emit the result
	} cmd_t;

	// datapath status to controller
	typedef struct packed {
		logic can_match;  // qty left, opposite non-empty
		logic crosses;    // top entry crosses (valid in TOP_CHK)
		logic removed;    // top fully consumed, sift down needed
		logic want_rest;  // remainder to rest and room exists
		logic down_more;  // sift down continues
		logic up_more;    // sift up continues
		logic at_root;    // sift up index is zero
	} sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/lobm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire lobm_pkg::sts_t  sts,
	output lobm_pkg::cmd_t       cmd
);

	lobm_pkg::state_t state_q, state_d;

	// hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lobm_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// sequence the match, sift and rest steps
	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != lobm_pkg::ST_IDLE);
		unique case (state_q)
			lobm_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = lobm_pkg::ST_TOP_RD;
				end
			end
			lobm_pkg::ST_TOP_RD: begin
				if (sts.can_match) begin
					cmd.rd_top = 1'b1;
					state_d = lobm_pkg::ST_TOP_CHK;
				end else if (sts.want_rest) begin
					cmd.rest = 1'b1;
					state_d = lobm_pkg::ST_UP_RD;
				end else begin
					state_d = lobm_pkg::ST_DONE;
				end
			end
			lobm_pkg::ST_TOP_CHK: begin
				if (sts.crosses) begin
					cmd.consume = 1'b1;
					state_d = sts.removed ? lobm_pkg::ST_DN_RD : lobm_pkg::ST_TOP_RD;
				end else if (sts.want_rest) begin
					cmd.rest = 1'b1;
					state_d = lobm_pkg::ST_UP_RD;
				end else begin
					state_d = lobm_pkg::ST_DONE;
				end
			end
			lobm_pkg::ST_DN_RD: begin
				cmd.rd_down = 1'b1;
				state_d = lobm_pkg::ST_DN_CMP;
			end
			lobm_pkg::ST_DN_CMP: begin
				cmd.step_down = 1'b1;
				state_d = sts.down_more ? lobm_pkg::ST_DN_RD : lobm_pkg::ST_TOP_RD;
			end
			lobm_pkg::ST_UP_RD: begin
				if (sts.at_root) begin
					state_d = lobm_pkg::ST_DONE;
				end else begin
					cmd.rd_up = 1'b1;
					state_d = lobm_pkg::ST_UP_CMP;
				end
			end
			lobm_pkg::ST_UP_CMP: begin
				cmd.step_up = 1'b1;
				state_d = sts.up_more ? lobm_pkg::ST_UP_RD : lobm_pkg::ST_DONE;
			end
			lobm_pkg::ST_DONE: begin
				cmd.done = 1'b1;
				state_d = lobm_pkg::ST_IDLE;
			end
			default: state_d = lobm_pkg::ST_IDLE;
		endcase
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == lobm_pkg::ST_IDLE)
		else $error("load outside idle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> state_q == lobm_pkg::ST_IDLE)
		else $error("done not followed by idle");
	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_down |=> cmd.step_down)
		else $error("sift down read without compare");

endmodule
`default_nettype wire

>>> hw/rtl/lobm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lobm_pkg::req_t  req,
	input  wire lobm_pkg::cmd_t  cmd,
	output lobm_pkg::sts_t       sts,
	output logic                 rsp_valid,
	output lobm_pkg::rsp_t       rsp
);

	localparam int AW = lobm_pkg::AddrW;
	localparam int CW = lobm_pkg::CountW;
	localparam int QW = lobm_pkg::QtyW;
	localparam int TW = lobm_pkg::TotalW;
	localparam logic [CW-1:0] Full = CW'(lobm_pkg::BookDepth);

	// book memories: two ports each, used as two reads or up to two writes a cycle
	lobm_pkg::entry_t buy_mem [lobm_pkg::BookDepth];
	lobm_pkg::entry_t sell_mem [lobm_pkg::BookDepth];

	logic [CW-1:0] buy_cnt_q, sell_cnt_q;
	logic [TW-1:0] total_q;
	lobm_pkg::req_t req_q;
	logic [QW-1:0] rested_q;
	logic full_q;
	logic [AW-1:0] idx_q;
	lobm_pkg::entry_t ins_q;     // entry moving during sift up / down
	lobm_pkg::entry_t rda_q, rdb_q;
	logic [CW-1:0] sift_n_q;     // count seen by sift down

	// selected books
	logic sell;
	logic [CW-1:0] opp_cnt, own_cnt;
	assign sell = req_q.is_sell;
	assign opp_cnt = sell ? buy_cnt_q : sell_cnt_q;
	assign own_cnt = sell ? sell_cnt_q : buy_cnt_q;

	// read and write addressing
	logic [AW-1:0] ra, rb, wa;
	logic we_opp, we_own, we2;
	logic [AW-1:0] wa2;
	lobm_pkg::entry_t wd, wd2;
	logic rd_opp;

	logic [CW:0] l_idx, r_idx;
	assign l_idx = {idx_q, 1'b1} + (CW+1)'(0);
	assign r_idx = l_idx + (CW+1)'(1);
	logic [AW-1:0] up_idx;
	assign up_idx = AW'((idx_q - AW'(1)) >> 1);

	// crossing and comparison
	logic crosses;
	assign crosses = sell ? (rda_q.price >= req_q.price) : (rda_q.price <= req_q.price);

	logic l_ok, r_ok, l_above, r_above_l, r_above;
	logic [AW-1:0] best_idx;
	lobm_pkg::entry_t best_e;
	function automatic logic above(input logic [29:0] a, input logic [29:0] b,
			input logic is_max);
		above = is_max ? (a > b) : (a < b);
	endfunction
	always_comb begin
		// opposite heap is max for a sell, min for a buy
		l_ok = l_idx < {1'b0, sift_n_q};
		r_ok = r_idx < {1'b0, sift_n_q};
		l_above = l_ok && above(rda_q.price, ins_q.price, sell);
		r_above_l = above(rdb_q.price, rda_q.price, sell);
		r_above = r_ok && (l_above ? r_above_l : above(rdb_q.price, ins_q.price, sell));
		best_idx = r_above ? AW'(r_idx) : AW'(l_idx);
		best_e = r_above ? rdb_q : rda_q;
	end
	logic up_above;
	assign up_above = above(ins_q.price, rda_q.price, !sell);

	always_comb begin
		ra = '0;
		rb = '0;
		rd_opp = 1'b1;
		if (cmd.rd_down) begin
			ra = AW'(l_idx);
			rb = AW'(r_idx);
		end else if (cmd.rd_up) begin
			ra = up_idx;
			rd_opp = 1'b0;
		end else if (cmd.consume) begin
			// fetch the tail entry that replaces a removed root
			rb = AW'(opp_cnt - CW'(1));
		end
		we_opp = 1'b0;
		we_own = 1'b0;
		we2 = 1'b0;
		wa = '0;
		wa2 = '0;
		wd = ins_q;
		wd2 = ins_q;
		if (cmd.consume && !sts.removed) begin
			we_opp = 1'b1;
			wd.price = rda_q.price;
			wd.qty = rda_q.qty - req_q.quantity;
		end else if (cmd.step_down) begin
			we_opp = 1'b1;
			wa = idx_q;
			wd = (l_above || r_above) ? best_e : ins_q;
			we2 = l_above || r_above;
			wa2 = best_idx;
		end else if (cmd.rest) begin
			we_own = 1'b1;
			wa = AW'(own_cnt);
			wd.price = req_q.price;
			wd.qty = req_q.quantity;
		end else if (cmd.step_up) begin
			we_own = 1'b1;
			wa = idx_q;
			wd = up_above ? rda_q : ins_q;
			we2 = up_above;
			wa2 = up_idx;
		end
	end

	// memory ports: each book has read ports a/b and write ports 1/2
	always_ff @(posedge clk) begin
		if (cmd.rd_top || cmd.rd_down || cmd.rd_up || (cmd.consume && sts.removed)) begin
			if (rd_opp == sell) begin
				rda_q <= buy_mem[ra];
				rdb_q <= buy_mem[rb];
			end else begin
				rda_q <= sell_mem[ra];
				rdb_q <= sell_mem[rb];
			end
		end
		if ((we_opp && sell) || (we_own && !sell)) begin
			buy_mem[wa] <= wd;
			if (we2) buy_mem[wa2] <= wd2;
		end
		if ((we_opp && !sell) || (we_own && sell)) begin
			sell_mem[wa] <= wd;
			if (we2) sell_mem[wa2] <= wd2;
		end
	end

	// status
	always_comb begin
		sts.can_match = (req_q.quantity != '0) && (opp_cnt != '0);
		sts.crosses = crosses;
		sts.removed = rda_q.qty <= req_q.quantity;
		sts.want_rest = (req_q.quantity != '0) && (own_cnt != Full);
		sts.down_more = l_above || r_above;
		sts.up_more = up_above;
		sts.at_root = (idx_q == '0);
	end

	// control registers: counts, total, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buy_cnt_q <= '0;
			sell_cnt_q <= '0;
			total_q <= '0;
			rsp_valid <= 1'b0;
		end else begin
			rsp_valid <= cmd.done;
			if (cmd.load && req.new_batch) begin
				buy_cnt_q <= '0;
				sell_cnt_q <= '0;
				total_q <= '0;
			end
			if (cmd.consume) begin
				if (sts.removed) begin
					if (sell) buy_cnt_q <= buy_cnt_q - CW'(1);
					else sell_cnt_q <= sell_cnt_q - CW'(1);
					total_q <= (TW'(rda_q.qty) > total_q) ? '0 : total_q - TW'(rda_q.qty);
				end else begin
					total_q <= (TW'(req_q.quantity) > total_q) ? '0
						: total_q - TW'(req_q.quantity);
				end
			end
			if (cmd.rest) begin
				if (sell) sell_cnt_q <= sell_cnt_q + CW'(1);
				else buy_cnt_q <= buy_cnt_q + CW'(1);
				total_q <= (total_q > ~TW'(req_q.quantity)) ? '1
					: total_q + TW'(req_q.quantity);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			rested_q <= '0;
			full_q <= 1'b0;
		end
		if (cmd.consume) begin
			if (sts.removed) begin
				req_q.quantity <= req_q.quantity - rda_q.qty;
				// move the last entry to the root and sift it down
				idx_q <= '0;
				sift_n_q <= opp_cnt - CW'(1);
			end else begin
				req_q.quantity <= '0;
			end
		end
		// take the tail entry fetched during the match as the moving entry
		if (cmd.rd_down && idx_q == '0) ins_q <= rdb_q;
		if (cmd.step_down) idx_q <= best_idx;
		if (cmd.rest) begin
			rested_q <= req_q.quantity;
			idx_q <= AW'(own_cnt);
			ins_q.price <= req_q.price;
			ins_q.qty <= req_q.quantity;
		end
		if (cmd.step_up) idx_q <= up_idx;
		if (cmd.done && req_q.quantity != '0 && own_cnt == Full && rested_q == '0)
			full_q <= 1'b1;
	end

	assign rsp.backlog_total = total_q;
	assign rsp.rested_quantity = rested_q;
	assign rsp.book_full = full_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		buy_cnt_q <= Full && sell_cnt_q <= Full)
		else $error("book count beyond depth");
	a_rest_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rest |-> own_cnt != Full)
		else $error("rest into full book");
	a_consume_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.consume |-> opp_cnt != '0)
		else $error("match against empty book");

endmodule
`default_nettype wire

>>> hw/rtl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Limit order book matcher.
// Request channel: present req with start high; it is taken on a clock edge
// where busy is low. Buys rest in a max-heap and sells in a min-heap, each
// held in an on-chip memory of lobm_pkg::BookDepth entries.
// Result channel: rsp is valid for exactly one cycle while rsp_valid is high;
// the receiver cannot stall and must take it then.
// Steps: the request is matched against resting opposite orders in turn until
// one does not cross, the opposite heap is sifted down after each order fully
// consumed, and a remainder that rests is sifted up toward the root; a sift
// walks at most log2(depth) levels. Busy stays high until the result cycle,
// so one request is in flight at a time and the next may be taken at the
// edge that ends the result cycle. The sift loops through the shared memory
// ports set the item time.
// book_full means a remainder was dropped as its own book was full.
// Reset empties both books and zeroes the backlog total at once; the book
// memories themselves are not cleared (only entries below the count are read).
module limit_order_book_matcher (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire lobm_pkg::req_t  req,
	output logic                 rsp_valid,
	output lobm_pkg::rsp_t       rsp
);

	lobm_pkg::cmd_t cmd;
	lobm_pkg::sts_t sts;

	lobm_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	lobm_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cmd      (cmd),
		.sts      (sts),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

>>> tb/limit_order_book_matcher_tb.sv
`timescale 1ns / 1ps
module limit_order_book_matcher_tb;

	localparam int SIDE_BUY = 0;
	localparam int SIDE_SELL = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	lobm_pkg::req_t req = '0;
	logic rsp_valid;
	lobm_pkg::rsp_t rsp;

	lobm_pkg::req_t order_q[$];
	lobm_pkg::rsp_t fill_q[$];
	int   issued = 0;
	bit   failed = 1'b0;

	// shadow books: buys are a max-heap, sells a min-heap
	lobm_pkg::entry_t           shadow_book[2][lobm_pkg::BookDepth];
	int unsigned                shadow_cnt[2];
	logic [lobm_pkg::TotalW-1:0] shadow_total;

	limit_order_book_matcher i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp(rsp)
	);

	always #2 clk = ~clk;

	function automatic bit outranks(int side, lobm_pkg::entry_t a, lobm_pkg::entry_t b);
		return (side == SIDE_BUY) ? (a.price > b.price) : (a.price < b.price);
	endfunction

	function automatic void book_push(int side, lobm_pkg::entry_t e);
		int unsigned i;
		int unsigned up;
		lobm_pkg::entry_t t;
		i = shadow_cnt[side];
		shadow_book[side][i] = e;
		shadow_cnt[side] = i + 1;
		while (i > 0) begin
			up = (i - 1) / 2;
			if (!outranks(side, shadow_book[side][i], shadow_book[side][up]))
				break;
			t = shadow_book[side][i];
			shadow_book[side][i] = shadow_book[side][up];
			shadow_book[side][up] = t;
			i = up;
		end
	endfunction

	function automatic void book_pop(int side);
		int unsigned n;
		int unsigned i;
		int unsigned best;
		int unsigned l;
		lobm_pkg::entry_t t;
		n = shadow_cnt[side] - 1;
		shadow_book[side][0] = shadow_book[side][n];
		shadow_cnt[side] = n;
		i = 0;
		forever begin
			best = i;
			l = 2 * i + 1;
			if (l < n && outranks(side, shadow_book[side][l], shadow_book[side][best]))
				best = l;
			if (l + 1 < n && outranks(side, shadow_book[side][l + 1], shadow_book[side][best]))
				best = l + 1;
			if (best == i)
				break;
			t = shadow_book[side][i];
			shadow_book[side][i] = shadow_book[side][best];
			shadow_book[side][best] = t;
			i = best;
		end
	endfunction

	// match one order against the shadow books and return its fill report
	function automatic lobm_pkg::rsp_t match_order(lobm_pkg::req_t r);
		lobm_pkg::rsp_t o;
		int own;
		int opp;
		logic [lobm_pkg::QtyW-1:0] left;
		lobm_pkg::entry_t top;
		bit crossed;
		lobm_pkg::entry_t e;
		o = '0;
		own = r.is_sell ? SIDE_SELL : SIDE_BUY;
		opp = r.is_sell ? SIDE_BUY : SIDE_SELL;
		left = r.quantity;
		if (r.new_batch) begin
			shadow_cnt[SIDE_BUY] = 0;
			shadow_cnt[SIDE_SELL] = 0;
			shadow_total = '0;
		end
		while (left > 0 && shadow_cnt[opp] > 0) begin
			top = shadow_book[opp][0];
			crossed = r.is_sell ? (top.price >= r.price) : (top.price <= r.price);
			if (!crossed)
				break;
			if (top.qty <= left) begin
				left -= top.qty;
				shadow_total = (top.qty > shadow_total) ? '0 : shadow_total - top.qty;
				book_pop(opp);
			end else begin
				shadow_book[opp][0].qty = top.qty - left;
				shadow_total = (left > shadow_total) ? '0 : shadow_total - left;
				left = '0;
			end
		end
		if (left > 0) begin
			if (shadow_cnt[own] < lobm_pkg::BookDepth) begin
				e.price = r.price;
				e.qty = left;
				book_push(own, e);
				shadow_total = ({1'b0, shadow_total} + left >
					{1'b0, {lobm_pkg::TotalW{1'b1}}}) ?
					{lobm_pkg::TotalW{1'b1}} : shadow_total + left;
				o.rested_quantity = left;
			end else begin
				o.book_full = 1'b1;
			end
		end
		o.backlog_total = shadow_total;
		return o;
	endfunction

	function automatic void queue_order(int unsigned p, int unsigned q, bit s, bit nb);
		lobm_pkg::req_t r;
		r.price = p[lobm_pkg::PriceW-1:0];
		r.quantity = q[lobm_pkg::QtyW-1:0];
		r.is_sell = s;
		r.new_batch = nb;
		order_q.push_back(r);
	endfunction

	// drive requests; predict the fill as each request is taken
	always @(posedge clk) begin
		bit hold;
		if (arst_n) begin
			if (start && !busy) begin
				fill_q.push_back(match_order(req));
				issued <= issued + 1;
			end
			if (!start || !busy) begin
				hold = (issued < 300 || issued > 600) && ($urandom_range(99) < 21);
				if (order_q.size() > 0 && !hold) begin
					start <= 1'b1;
					req <= order_q.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// check each result against the oldest prediction
	always @(posedge clk) begin
		lobm_pkg::rsp_t want;
		if (arst_n && rsp_valid) begin
			if (fill_q.size() == 0) begin
				$error("unexpected result: backlog_total %0d", rsp.backlog_total);
				failed = 1'b1;
			end else begin
				want = fill_q.pop_front();
				if (rsp.backlog_total !== want.backlog_total) begin
					$error("backlog_total: expected %0d, got %0d",
						want.backlog_total, rsp.backlog_total);
					failed = 1'b1;
				end
				if (rsp.rested_quantity !== want.rested_quantity) begin
					$error("rested_quantity: expected %0d, got %0d",
						want.rested_quantity, rsp.rested_quantity);
					failed = 1'b1;
				end
				if (rsp.book_full !== want.book_full) begin
					$error("book_full: expected %0d, got %0d",
						want.book_full, rsp.book_full);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int total;
		int base;
		shadow_cnt[SIDE_BUY] = 0;
		shadow_cnt[SIDE_SELL] = 0;
		shadow_total = '0;

		// directed: zero quantity, extremes, partial and full fills, clear
		queue_order('0, '0, 1'b0, 1'b0);
		queue_order('1, '1, 1'b0, 1'b0);
		queue_order('1, '0, 1'b1, 1'b0);
		queue_order('1, 5, 1'b1, 1'b0);
		queue_order('0, '1, 1'b1, 1'b0);
		queue_order('0, '1, 1'b1, 1'b1);
		queue_order('1, 10, 1'b0, 1'b0);
		queue_order(100, 10, 1'b0, 1'b1);
		queue_order(100, 4, 1'b1, 1'b0);
		queue_order(90, 20, 1'b1, 1'b0);
		queue_order(120, 3, 1'b1, 1'b0);
		queue_order(95, 50, 1'b0, 1'b0);
		queue_order(120, 40, 1'b0, 1'b0);
		queue_order(50, 15, 1'b0, 1'b0);
		queue_order(40, 100, 1'b1, 1'b0);
		queue_order('h2AAAAAAA, 'h15555555, 1'b0, 1'b1);
		queue_order('h15555555, 'h2AAAAAAA, 1'b1, 1'b0);

		// fill the buy book to capacity, then overflow it
		queue_order($urandom_range(500), $urandom, 1'b0, 1'b1);
		for (int i = 0; i < lobm_pkg::BookDepth + 3; i++)
			queue_order($urandom_range(500), $urandom, 1'b0, 1'b0);
		// sweep part of the full book
		for (int i = 0; i < 20; i++)
			queue_order($urandom_range(500), $urandom_range(32'h3FFF_FFFF), 1'b1, 1'b0);

		// random trading around a moving price band
		base = 1000;
		for (int i = 0; i < 380; i++) begin
			if ($urandom_range(9) == 0)
				queue_order($urandom, $urandom, $urandom_range(1) == 1,
					$urandom_range(24) == 0);
			else
				queue_order(base + $urandom_range(40) - 20, $urandom_range(100),
					$urandom_range(1) == 1, $urandom_range(60) == 0);
			if ($urandom_range(30) == 0)
				base = $urandom_range(1 << 29) + 100;
		end
		total = order_q.size() + 0;
		total = total + issued;

		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		wait (issued == total && fill_q.size() == 0);
		repeat (50) @(posedge clk);
		if (!failed && fill_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#40ms;
		$display("Verification failed");
		$finish;
	end

endmodule
